>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. Defining NO_ASSERTIONS removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/core/mcpr_pkg.sv
`timescale 1ns / 1ps

package mcpr_pkg;

    localparam int SET_DEPTH_DEF = 64;
    localparam int PAGE_BITS_DEF = 20;

    localparam int SLOT_W = 6;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] SET_SIZE_RST = 7'd64;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FAULT  = 1'b1;

    typedef struct packed {
        logic touch;
        logic touch_wr;
        logic clear_used;
        logic place;
        logic place_mod;
    } flag_cmd_t;

    typedef struct packed {
        logic valid;
        logic used;
        logic modified;
    } flag_t;

endpackage

>>> rtl/core/mcpr_ram.sv
`timescale 1ns / 1ps

module mcpr_ram #(
    parameter int WIDTH = mcpr_pkg::PAGE_BITS_DEF,
    parameter int DEPTH = mcpr_pkg::SET_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mcpr_flags.sv
`timescale 1ns / 1ps

module mcpr_flags #(
    parameter int SET_DEPTH = mcpr_pkg::SET_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(SET_DEPTH)-1:0] addr,
    input  mcpr_pkg::flag_cmd_t          cmd,
    output mcpr_pkg::flag_t              rd
);

    logic [SET_DEPTH-1:0] valid_reg;
    logic [SET_DEPTH-1:0] used_reg;
    logic [SET_DEPTH-1:0] mod_reg;

    assign rd.valid    = valid_reg[addr];
    assign rd.used     = used_reg[addr];
    assign rd.modified = mod_reg[addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
            mod_reg   <= '0;
        end
        else
        begin
            if (cmd.touch && valid_reg[addr])
            begin
                used_reg[addr] <= 1'b1;
                if (cmd.touch_wr)
                begin
                    mod_reg[addr] <= 1'b1;
                end
            end
            if (cmd.clear_used)
            begin
                used_reg[addr] <= 1'b0;
            end
            if (cmd.place)
            begin
                valid_reg[addr] <= 1'b1;
                used_reg[addr]  <= 1'b1;
                mod_reg[addr]   <= cmd.place_mod;
            end
        end
    end

endmodule

>>> rtl/core/mcpr_seq.sv
`timescale 1ns / 1ps

module mcpr_seq #(
    parameter int SET_DEPTH = mcpr_pkg::SET_DEPTH_DEF,
    parameter int PAGE_BITS = mcpr_pkg::PAGE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(SET_DEPTH+1)-1:0]   size,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [PAGE_BITS-1:0]             page_number,
    input  logic [$clog2(SET_DEPTH)-1:0]     slot_index,
    input  logic                             is_write,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [$clog2(SET_DEPTH)-1:0]     placed_slot,
    output logic                             evicted,
    output logic [PAGE_BITS-1:0]             evicted_page,
    output logic                             evicted_dirty,
    output logic [$clog2(SET_DEPTH)-1:0]     flag_addr,
    output mcpr_pkg::flag_cmd_t              flag_cmd,
    input  mcpr_pkg::flag_t                  flag_rd,
    output logic                             ram_we,
    output logic [$clog2(SET_DEPTH)-1:0]     ram_waddr,
    output logic [PAGE_BITS-1:0]             ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(SET_DEPTH)-1:0]     ram_raddr,
    input  logic [PAGE_BITS-1:0]             ram_rdata
);

    localparam int IDX_W  = $clog2(SET_DEPTH);
    localparam int CNT_W  = $clog2(SET_DEPTH + 1);
    localparam int WIDE_W = CNT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t                      state_reg,   state_next;
    logic [IDX_W-1:0]            hand_reg,    hand_next;
    logic [CNT_W-1:0]            filled_reg,  filled_next;
    logic [IDX_W-1:0]            idx_reg,     idx_next;
    logic [IDX_W-1:0]            cnt_reg,     cnt_next;
    logic                        phase_reg,   phase_next;
    logic [PAGE_BITS-1:0]        page_reg,    page_next;
    logic                        wr_reg,      wr_next;
    logic                        evict_reg,   evict_next;
    logic                        dirty_reg,   dirty_next;
    logic                        ovalid_reg,  ovalid_next;
    logic [IDX_W-1:0]            oslot_reg,   oslot_next;
    logic                        oevict_reg,  oevict_next;
    logic [PAGE_BITS-1:0]        opage_reg,   opage_next;
    logic                        odirty_reg,  odirty_next;

    logic [IDX_W-1:0] hand_eff;
    logic [IDX_W-1:0] idx_inc;
    logic             found;
    logic             pass_end;

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = ovalid_reg;
    assign placed_slot   = oslot_reg;
    assign evicted       = oevict_reg;
    assign evicted_page  = opage_reg;
    assign evicted_dirty = odirty_reg;

    assign hand_eff = (WIDE_W'(hand_reg) >= WIDE_W'(size)) ? '0 : hand_reg;
    assign idx_inc  = ((WIDE_W'(idx_reg) + WIDE_W'(1)) == WIDE_W'(size)) ? '0
                    : idx_reg + IDX_W'(1);
    assign pass_end = ((WIDE_W'(cnt_reg) + WIDE_W'(1)) == WIDE_W'(size));
    assign found    = !flag_rd.valid
                    || (!phase_reg && !flag_rd.used && !flag_rd.modified)
                    || (phase_reg && !flag_rd.used);

    always_comb
    begin
        state_next  = state_reg;
        hand_next   = hand_reg;
        filled_next = filled_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        page_next   = page_reg;
        wr_next     = wr_reg;
        evict_next  = evict_reg;
        dirty_next  = dirty_reg;
        ovalid_next = ovalid_reg;
        oslot_next  = oslot_reg;
        oevict_next = oevict_reg;
        opage_next  = opage_reg;
        odirty_next = odirty_reg;
        flag_addr   = idx_reg;
        flag_cmd    = '0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = page_reg;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                flag_addr = slot_index;
                if (in_valid)
                begin
                    if (operation == mcpr_pkg::OP_ACCESS)
                    begin
                        flag_cmd.touch    = (WIDE_W'(slot_index) < WIDE_W'(SET_DEPTH));
                        flag_cmd.touch_wr = is_write;
                    end
                    else
                    begin
                        page_next  = page_number;
                        wr_next    = is_write;
                        idx_next   = hand_eff;
                        cnt_next   = '0;
                        phase_next = 1'b0;
                        state_next = (filled_reg < size) ? ST_READ : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    flag_cmd.clear_used = phase_reg;
                    idx_next = idx_inc;
                    if (pass_end)
                    begin
                        cnt_next   = '0;
                        phase_next = !phase_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                evict_next = flag_rd.valid;
                dirty_next = flag_rd.modified;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ram_we             = 1'b1;
                    flag_cmd.place     = 1'b1;
                    flag_cmd.place_mod = wr_reg;
                    ovalid_next        = 1'b1;
                    oslot_next         = idx_reg;
                    oevict_next        = evict_reg;
                    opage_next         = evict_reg ? ram_rdata : '0;
                    odirty_next        = evict_reg && dirty_reg;
                    hand_next          = idx_inc;
                    if (!evict_reg && (WIDE_W'(filled_reg) < WIDE_W'(SET_DEPTH)))
                    begin
                        filled_next = filled_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hand_reg   <= '0;
            filled_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hand_reg   <= hand_next;
            filled_reg <= filled_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        phase_reg  <= phase_next;
        page_reg   <= page_next;
        wr_reg     <= wr_next;
        evict_reg  <= evict_next;
        dirty_reg  <= dirty_next;
        oslot_reg  <= oslot_next;
        oevict_reg <= oevict_next;
        opage_reg  <= opage_next;
        odirty_reg <= odirty_next;
    end

endmodule

>>> rtl/core/modified_clock_page_replacer.sv
// An access transaction is taken while idle and gives no result.
// A fault transaction reads and writes the slot at the hand while the set is not full; when
// full, the scan tests one slot a cycle over at most three passes and one slot, then reads
// and writes the found slot. A write waits while a result is stalled; one fault at a time.
// Reset is asynchronous and active low: flags, hand and fill count clear, size is the depth.
// The page store is not cleared; no clearing pass is run.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module modified_clock_page_replacer #(
    parameter int SET_DEPTH = mcpr_pkg::SET_DEPTH_DEF,
    parameter int PAGE_BITS = mcpr_pkg::PAGE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [$clog2(SET_DEPTH+1)-1:0] set_size,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [PAGE_BITS-1:0]           page_number,
    input  logic [$clog2(SET_DEPTH)-1:0]   slot_index,
    input  logic                           is_write,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [$clog2(SET_DEPTH)-1:0]   placed_slot,
    output logic                           evicted,
    output logic [PAGE_BITS-1:0]           evicted_page,
    output logic                           evicted_dirty
);

    localparam int IDX_W  = $clog2(SET_DEPTH);
    localparam int CNT_W  = $clog2(SET_DEPTH + 1);
    localparam int WIDE_W = CNT_W + 1;

    logic [CNT_W-1:0]           set_size_reg;
    logic [CNT_W-1:0]           size;
    logic [IDX_W-1:0]           flag_addr;
    mcpr_pkg::flag_cmd_t        flag_cmd;
    mcpr_pkg::flag_t            flag_rd;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [PAGE_BITS-1:0]       ram_wdata;
    logic                       ram_re;
    logic [IDX_W-1:0]           ram_raddr;
    logic [PAGE_BITS-1:0]       ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg <= CNT_W'(SET_DEPTH);
        end
        else if (cfg_write)
        begin
            set_size_reg <= set_size;
        end
    end

    // The active size is the register value held within one and the table depth.
    always_comb
    begin
        if (set_size_reg == '0)
        begin
            size = CNT_W'(1);
        end
        else if (WIDE_W'(set_size_reg) > WIDE_W'(SET_DEPTH))
        begin
            size = CNT_W'(SET_DEPTH);
        end
        else
        begin
            size = set_size_reg;
        end
    end

    mcpr_seq #(
        .SET_DEPTH (SET_DEPTH),
        .PAGE_BITS (PAGE_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .size          (size),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .page_number   (page_number),
        .slot_index    (slot_index),
        .is_write      (is_write),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .placed_slot   (placed_slot),
        .evicted       (evicted),
        .evicted_page  (evicted_page),
        .evicted_dirty (evicted_dirty),
        .flag_addr     (flag_addr),
        .flag_cmd      (flag_cmd),
        .flag_rd       (flag_rd),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    mcpr_flags #(
        .SET_DEPTH (SET_DEPTH)
    ) u_flags (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (flag_addr),
        .cmd   (flag_cmd),
        .rd    (flag_rd)
    );

    mcpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (SET_DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A result only appears at the end of a fault, while the input side is held off.
    `ASSERT_ALWAYS(a_result_from_fault, clk, rst_n, $rose(out_valid) |-> $past(in_stall))
    `ASSERT_NEXT(a_fault_busy, clk, rst_n, in_valid && !in_stall && (operation == mcpr_pkg::OP_FAULT), in_stall)
    `ASSERT_NEXT(a_access_single, clk, rst_n, in_valid && !in_stall && (operation == mcpr_pkg::OP_ACCESS), !in_stall)

endmodule
